### src/lli_pkg.sv
`timescale 1ns / 1ps
// Shared widths and pipeline payload types for the line-line intersection block.
// No dependencies; imported by every module of the block.
package lli_pkg;

   localparam int COORD_WIDTH = 31;
   localparam int W           = COORD_WIDTH;
   localparam int DIFF_W      = W + 1;          // base difference
   localparam int NUM_W       = 2 * W + 2;      // signed numerator
   localparam int DENS_W      = 2 * W + 1;      // signed denominator
   localparam int MNUM_W      = 2 * W + 1;      // numerator magnitude
   localparam int MDEN_W      = 2 * W;          // denominator magnitude
   localparam int LO_W        = MNUM_W / 2;     // low slice of the split product
   localparam int HI_W        = MNUM_W - LO_W;
   localparam int QW          = 3 * W;          // product and quotient width
   localparam int RES_W       = 64;
   localparam int QX          = (3 * W + 1 > RES_W + 1) ? 3 * W + 1 : RES_W + 1;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_PARALLEL = 2'd1;
   localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

   typedef struct packed {
      logic                neg;
      logic                par;
      logic signed [W-1:0] base;
   } tag_type;

   typedef struct packed {
      logic [QW-1:0]     prod;
      logic [MDEN_W-1:0] dsr;
      tag_type           tag;
   } div_in_type;

   typedef struct packed {
      logic [QW-1:0]     quo;
      logic [MDEN_W-1:0] rem;
      logic [MDEN_W-1:0] dsr;
      tag_type           tag;
   } div_out_type;

endpackage

### src/lli_front.sv
`timescale 1ns / 1ps
// Front pipeline: differences, cross products, magnitudes and the split
// numerator-direction product for both coordinates. Uses lli_pkg.
module lli_front
   import lli_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                adv,
   input  logic                in_valid,
   input  logic signed [W-1:0] b1x,
   input  logic signed [W-1:0] b1y,
   input  logic signed [W-1:0] d1x,
   input  logic signed [W-1:0] d1y,
   input  logic signed [W-1:0] b2x,
   input  logic signed [W-1:0] b2y,
   input  logic signed [W-1:0] d2x,
   input  logic signed [W-1:0] d2y,
   output logic                out_valid,
   output div_in_type          out_x,
   output div_in_type          out_y
);

   logic [5:0] v_ff;

   // stage 1
   logic signed [W-1:0]      b1x_ff, b1y_ff, d1x_ff, d1y_ff, d2x_ff, d2y_ff;
   logic signed [DIFF_W-1:0] ex_ff, ey_ff;
   // stage 2
   logic signed [W-1:0]      b1x2_ff, b1y2_ff, d1x2_ff, d1y2_ff;
   logic signed [2*W:0]      px_ff, py_ff;
   logic signed [2*W-1:0]    q0_ff, q1_ff;
   // stage 3
   logic signed [W-1:0]      b1x3_ff, b1y3_ff, d1x3_ff, d1y3_ff;
   logic signed [NUM_W-1:0]  num_ff;
   logic signed [DENS_W-1:0] den_ff;
   // stage 4
   logic signed [W-1:0]      b1x4_ff, b1y4_ff;
   logic [MNUM_W-1:0]        mnum_ff;
   logic [W-1:0]             mdx_ff, mdy_ff;
   logic [MDEN_W-1:0]        mden4_ff;
   logic                     negx4_ff, negy4_ff, par4_ff;
   // stage 5
   logic signed [W-1:0]      b1x5_ff, b1y5_ff;
   logic [LO_W+W-1:0]        plx_ff, ply_ff;
   logic [HI_W+W-1:0]        phx_ff, phy_ff;
   logic [MDEN_W-1:0]        mden5_ff;
   logic                     negx5_ff, negy5_ff, par5_ff;
   // stage 6
   div_in_type               outx_ff, outy_ff;

   logic signed [NUM_W-1:0]  nabs;
   logic signed [W:0]        dxe, dye, dxa, dya;
   logic signed [DENS_W-1:0] dabs;
   logic                     sn, sd;

   always_comb begin
      nabs = num_ff[NUM_W-1] ? -num_ff : num_ff;
      dxe  = {d1x3_ff[W-1], d1x3_ff};
      dye  = {d1y3_ff[W-1], d1y3_ff};
      dxa  = dxe[W] ? -dxe : dxe;
      dya  = dye[W] ? -dye : dye;
      dabs = den_ff[DENS_W-1] ? -den_ff : den_ff;
      sn   = num_ff[NUM_W-1];
      sd   = den_ff[DENS_W-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= {v_ff[4:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         b1x_ff <= b1x;
         b1y_ff <= b1y;
         d1x_ff <= d1x;
         d1y_ff <= d1y;
         d2x_ff <= d2x;
         d2y_ff <= d2y;
         ex_ff  <= {b2x[W-1], b2x} - {b1x[W-1], b1x};
         ey_ff  <= {b2y[W-1], b2y} - {b1y[W-1], b1y};

         b1x2_ff <= b1x_ff;
         b1y2_ff <= b1y_ff;
         d1x2_ff <= d1x_ff;
         d1y2_ff <= d1y_ff;
         px_ff   <= (2*W+1)'(ex_ff) * (2*W+1)'(d2y_ff);
         py_ff   <= (2*W+1)'(ey_ff) * (2*W+1)'(d2x_ff);
         q0_ff   <= (2*W)'(d1x_ff) * (2*W)'(d2y_ff);
         q1_ff   <= (2*W)'(d1y_ff) * (2*W)'(d2x_ff);

         b1x3_ff <= b1x2_ff;
         b1y3_ff <= b1y2_ff;
         d1x3_ff <= d1x2_ff;
         d1y3_ff <= d1y2_ff;
         num_ff  <= NUM_W'(px_ff) - NUM_W'(py_ff);
         den_ff  <= DENS_W'(q0_ff) - DENS_W'(q1_ff);

         b1x4_ff  <= b1x3_ff;
         b1y4_ff  <= b1y3_ff;
         mnum_ff  <= nabs[MNUM_W-1:0];
         mdx_ff   <= dxa[W-1:0];
         mdy_ff   <= dya[W-1:0];
         mden4_ff <= dabs[MDEN_W-1:0];
         negx4_ff <= sn ^ d1x3_ff[W-1] ^ sd;
         negy4_ff <= sn ^ d1y3_ff[W-1] ^ sd;
         par4_ff  <= (den_ff == '0);

         b1x5_ff  <= b1x4_ff;
         b1y5_ff  <= b1y4_ff;
         plx_ff   <= (LO_W+W)'(mnum_ff[LO_W-1:0]) * (LO_W+W)'(mdx_ff);
         ply_ff   <= (LO_W+W)'(mnum_ff[LO_W-1:0]) * (LO_W+W)'(mdy_ff);
         phx_ff   <= (HI_W+W)'(mnum_ff[MNUM_W-1:LO_W]) * (HI_W+W)'(mdx_ff);
         phy_ff   <= (HI_W+W)'(mnum_ff[MNUM_W-1:LO_W]) * (HI_W+W)'(mdy_ff);
         mden5_ff <= mden4_ff;
         negx5_ff <= negx4_ff;
         negy5_ff <= negy4_ff;
         par5_ff  <= par4_ff;

         outx_ff.prod     <= QW'({phx_ff, {LO_W{1'b0}}}) + QW'(plx_ff);
         outx_ff.dsr      <= mden5_ff;
         outx_ff.tag.neg  <= negx5_ff;
         outx_ff.tag.par  <= par5_ff;
         outx_ff.tag.base <= b1x5_ff;
         outy_ff.prod     <= QW'({phy_ff, {LO_W{1'b0}}}) + QW'(ply_ff);
         outy_ff.dsr      <= mden5_ff;
         outy_ff.tag.neg  <= negy5_ff;
         outy_ff.tag.par  <= par5_ff;
         outy_ff.tag.base <= b1y5_ff;
      end
   end

   assign out_valid = v_ff[5];
   assign out_x     = outx_ff;
   assign out_y     = outy_ff;

endmodule

### src/lli_div.sv
`timescale 1ns / 1ps
// Pipelined restoring divider, one quotient bit per stage, for one coordinate.
// Uses lli_pkg.
module lli_div
   import lli_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        adv,
   input  logic        in_valid,
   input  div_in_type  din,
   output logic        out_valid,
   output div_out_type dout
);

   logic [MDEN_W-1:0] rem_ff [1:QW];
   logic [QW-1:0]     dvd_ff [1:QW];
   logic [QW-1:0]     quo_ff [1:QW];
   logic [MDEN_W-1:0] dsr_ff [1:QW];
   tag_type           tag_ff [1:QW];
   logic [QW:1]       v_ff;

   for (genvar k = 1; k <= QW; k++) begin : g_stage
      logic [MDEN_W-1:0] rem_p;
      logic [MDEN_W-1:0] dsr_p;
      logic [QW-1:0]     dvd_p;
      logic [QW-1:0]     quo_p;
      tag_type           tag_p;
      logic              v_p;
      logic [MDEN_W:0]   t;
      logic [MDEN_W:0]   diff;
      logic              ge;

      if (k == 1) begin : g_first
         assign rem_p = '0;
         assign dvd_p = din.prod;
         assign quo_p = '0;
         assign dsr_p = din.dsr;
         assign tag_p = din.tag;
         assign v_p   = in_valid;
      end else begin : g_next
         assign rem_p = rem_ff[k-1];
         assign dvd_p = dvd_ff[k-1];
         assign quo_p = quo_ff[k-1];
         assign dsr_p = dsr_ff[k-1];
         assign tag_p = tag_ff[k-1];
         assign v_p   = v_ff[k-1];
      end

      always_comb begin
         t    = {rem_p, dvd_p[QW-1]};
         diff = t - {1'b0, dsr_p};
         ge   = (t >= {1'b0, dsr_p});
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (adv) begin
            v_ff[k] <= v_p;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[k] <= ge ? diff[MDEN_W-1:0] : t[MDEN_W-1:0];
            dvd_ff[k] <= {dvd_p[QW-2:0], 1'b0};
            quo_ff[k] <= {quo_p[QW-2:0], ge};
            dsr_ff[k] <= dsr_p;
            tag_ff[k] <= tag_p;
         end
      end
   end

   assign out_valid = v_ff[QW];
   assign dout.quo  = quo_ff[QW];
   assign dout.rem  = rem_ff[QW];
   assign dout.dsr  = dsr_ff[QW];
   assign dout.tag  = tag_ff[QW];

endmodule

### src/lli_back.sv
`timescale 1ns / 1ps
// Back pipeline: rounding, base offset, range check and the output register.
// Uses lli_pkg.
module lli_back
   import lli_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             adv,
   input  logic             vx,
   input  logic             vy,
   input  div_out_type      dx,
   input  div_out_type      dy,
   output logic             out_valid,
   output logic [RES_W-1:0] out_x,
   output logic [RES_W-1:0] out_y,
   output logic [1:0]       out_status
);

   logic [2:0]                v_ff;
   logic [RES_W-1:0]          qx_ff, qy_ff;
   logic                      ovf1_ff, par1_ff, negx_ff, negy_ff;
   logic signed [W-1:0]       bx_ff, by_ff;
   logic signed [RES_W:0]     sx_ff, sy_ff;
   logic                      ovf2_ff, par2_ff;
   logic [RES_W-1:0]          ox_ff, oy_ff;
   logic [1:0]                st_ff;

   logic [QX-1:0]             rqx, rqy;
   logic                      rndx, rndy;
   logic signed [RES_W:0]     bxe, bye, qxe, qye, sx_in, sy_in;

   always_comb begin
      // half away from zero: bump when twice the remainder reaches the divisor
      rndx  = ({dx.rem, 1'b0} >= {1'b0, dx.dsr});
      rndy  = ({dy.rem, 1'b0} >= {1'b0, dy.dsr});
      rqx   = QX'(dx.quo) + QX'(rndx);
      rqy   = QX'(dy.quo) + QX'(rndy);
      bxe   = (RES_W+1)'(bx_ff);
      bye   = (RES_W+1)'(by_ff);
      qxe   = {1'b0, qx_ff};
      qye   = {1'b0, qy_ff};
      sx_in = negx_ff ? bxe - qxe : bxe + qxe;
      sy_in = negy_ff ? bye - qye : bye + qye;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= {v_ff[1:0], vx & vy};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         qx_ff   <= rqx[RES_W-1:0];
         qy_ff   <= rqy[RES_W-1:0];
         ovf1_ff <= (|rqx[QX-1:RES_W]) | (|rqy[QX-1:RES_W]);
         par1_ff <= dx.tag.par | dy.tag.par;
         negx_ff <= dx.tag.neg;
         negy_ff <= dy.tag.neg;
         bx_ff   <= dx.tag.base;
         by_ff   <= dy.tag.base;

         sx_ff   <= sx_in;
         sy_ff   <= sy_in;
         ovf2_ff <= ovf1_ff;
         par2_ff <= par1_ff;

         if (par2_ff) begin
            st_ff <= STATUS_PARALLEL;
            ox_ff <= '0;
            oy_ff <= '0;
         end else if (ovf2_ff || (sx_ff[RES_W] != sx_ff[RES_W-1])
                      || (sy_ff[RES_W] != sy_ff[RES_W-1])) begin
            st_ff <= STATUS_OVERFLOW;
            ox_ff <= '0;
            oy_ff <= '0;
         end else begin
            st_ff <= STATUS_OK;
            ox_ff <= sx_ff[RES_W-1:0];
            oy_ff <= sy_ff[RES_W-1:0];
         end
      end
   end

   assign out_valid  = v_ff[2];
   assign out_x      = ox_ff;
   assign out_y      = oy_ff;
   assign out_status = st_ff;

endmodule

### src/line_line_intersection.sv
`timescale 1ns / 1ps
// Line-line intersection top level: front pipeline, two dividers, back pipeline.
// Depends on lli_pkg, lli_front, lli_div, lli_back.
//
// Takes one request per cycle and returns one response per request, in order.
// Requests pass through the front pipeline, the restoring divider that produces one
// quotient bit per stage, and the back pipeline. The whole pipeline holds while a
// response waits untaken; req_tready is low only then. Parallel lines give status 1
// with zero coordinates, out-of-range results status 2.
module line_line_intersection
   import lli_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_tvalid,
   output logic           req_tready,
   // first_base_x, first_base_y, first_dir_x, first_dir_y,
   // second_base_x, second_base_y, second_dir_x, second_dir_y (31 bits each)
   input  logic [247:0]   req_tdata,
   output logic           rsp_tvalid,
   input  logic           rsp_tready,
   // cross_x [63:0], cross_y [127:64]
   output logic [127:0]   rsp_tdata,
   // status [1:0]
   output logic [1:0]     rsp_tuser
);

   logic        adv;
   logic        fv, vx, vy;
   div_in_type  fx, fy;
   div_out_type dx, dy;

   assign adv        = !rsp_tvalid || rsp_tready;
   assign req_tready = adv;

   lli_front u_front (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_valid (req_tvalid),
      .b1x      (req_tdata[0*W +: W]),
      .b1y      (req_tdata[1*W +: W]),
      .d1x      (req_tdata[2*W +: W]),
      .d1y      (req_tdata[3*W +: W]),
      .b2x      (req_tdata[4*W +: W]),
      .b2y      (req_tdata[5*W +: W]),
      .d2x      (req_tdata[6*W +: W]),
      .d2y      (req_tdata[7*W +: W]),
      .out_valid(fv),
      .out_x    (fx),
      .out_y    (fy)
   );

   lli_div u_div_x (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_valid (fv),
      .din      (fx),
      .out_valid(vx),
      .dout     (dx)
   );

   lli_div u_div_y (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_valid (fv),
      .din      (fy),
      .out_valid(vy),
      .dout     (dy)
   );

   lli_back u_back (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .vx        (vx),
      .vy        (vy),
      .dx        (dx),
      .dy        (dy),
      .out_valid (rsp_tvalid),
      .out_x     (rsp_tdata[63:0]),
      .out_y     (rsp_tdata[127:64]),
      .out_status(rsp_tuser)
   );

endmodule

### src/lli_checker.sv
`timescale 1ns / 1ps
// Port-level checks for line_line_intersection, bound to the top level.
// Depends on lli_pkg for status codes.
module lli_checker
   import lli_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         req_tready,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [127:0] rsp_tdata,
   input logic [1:0]   rsp_tuser
);

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
                                    && $stable(rsp_tuser))
      else $error("stalled response changed");

   a_zero_on_fault: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == STATUS_PARALLEL || rsp_tuser == STATUS_OVERFLOW)
      |-> rsp_tdata == '0)
      else $error("nonzero coordinates with fault status");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser == STATUS_OK || rsp_tuser == STATUS_PARALLEL
                      || rsp_tuser == STATUS_OVERFLOW))
      else $error("undefined status code");

   a_ready_follows: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("request stalled with empty output");

endmodule

bind line_line_intersection lli_checker u_lli_checker (
   .clock     (clock),
   .reset     (reset),
   .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata (rsp_tdata),
   .rsp_tuser (rsp_tuser)
);

### bench/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for line_line_intersection: random and corner line pairs,
// expected crossing points computed exactly in 128-bit arithmetic. Depends on lli_pkg.
module tb_top;
   import lli_pkg::*;

   typedef struct packed {
      logic signed [30:0] d2y, d2x, b2y, b2x, d1y, d1x, b1y, b1x;
   } lines_t;

   typedef struct {
      logic [63:0] x;
      logic [63:0] y;
      logic [1:0]  st;
   } cross_t;

   logic         clock = 0;
   logic         reset = 1;
   logic         req_tvalid = 0;
   logic         req_tready;
   logic [247:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 0;
   logic [127:0] rsp_tdata;
   logic [1:0]   rsp_tuser;

   line_line_intersection dut (.*);

   initial forever #6 clock = ~clock;

   lines_t pending_lines[$];
   cross_t expected_points[$];
   int     mismatches = 0;
   int     cycles = 0;
   bit     stim_done = 0;
   bit     quiet = 0;          // no idling in the final part
   bit     drain_hold = 0;     // sender waits for all responses
   int     hold_cycles = 0;    // receiver long hold-off

   // base + round(num*dir/den), half away from zero; returns 0 on overflow
   function automatic bit crossing_coord(input logic signed [63:0] base, num, dir, den,
                                         output logic [63:0] res);
      logic signed [127:0] prod, d, q, r, full;
      prod = 128'(num) * 128'(dir);
      d = 128'(den);
      if (d < 0) begin
         d = -d;
         prod = -prod;
      end
      q = prod / d;
      r = prod % d;
      if (r < 0) r = -r;
      if (2 * r >= d) q = (prod < 0) ? q - 1 : q + 1;
      full = 128'(base) + q;
      res = full[63:0];
      return full >= -(128'sd1 <<< 63) && full < (128'sd1 <<< 63);
   endfunction

   function automatic cross_t predict_crossing(input lines_t l);
      cross_t c;
      logic signed [63:0] num, den;
      bit okx, oky;
      num = (64'(l.b2x) - l.b1x) * l.d2y - (64'(l.b2y) - l.b1y) * l.d2x;
      den = 64'(l.d1x) * l.d2y - 64'(l.d1y) * l.d2x;
      c.x = '0; c.y = '0;
      if (den == 0) begin
         c.st = STATUS_PARALLEL;
         return c;
      end
      okx = crossing_coord(l.b1x, num, l.d1x, den, c.x);
      oky = crossing_coord(l.b1y, num, l.d1y, den, c.y);
      if (okx && oky) c.st = STATUS_OK;
      else begin
         c.st = STATUS_OVERFLOW;
         c.x = '0; c.y = '0;
      end
      return c;
   endfunction

   function automatic logic signed [30:0] rnd_coord(input int mode);
      case (mode)
         0: return 31'($urandom);
         1: return 31'($signed($urandom_range(0, 40)) - 20);
         2: return ($urandom_range(0, 1)) ? 31'h3fffffff : 31'h40000000;
         default: return 31'($signed($urandom_range(0, 2000)) - 1000);
      endcase
   endfunction

   function automatic lines_t rnd_lines();
      lines_t l;
      int m;
      m = $urandom_range(0, 9);
      l.b1x = rnd_coord(m % 4); l.b1y = rnd_coord($urandom_range(0, 3));
      l.d1x = rnd_coord(m % 4); l.d1y = rnd_coord($urandom_range(0, 3));
      l.b2x = rnd_coord(m % 4); l.b2y = rnd_coord($urandom_range(0, 3));
      l.d2x = rnd_coord(m % 4); l.d2y = rnd_coord($urandom_range(0, 3));
      if (m == 9) begin
         // parallel: second direction a multiple of the first
         l.d2x = l.d1x * 3;
         l.d2y = l.d1y * 3;
      end
      return l;
   endfunction

   initial begin
      lines_t l;
      int i;
      // directed: extremes, parallel, zero direction, overflow
      l = '0; pending_lines.push_back(l);
      l = '{31'd1, 31'd0, 31'd0, 31'd0, 31'd0, 31'd1, 31'd0, 31'd0};
      pending_lines.push_back(l);                  // x axis meets y axis
      l = '{31'd2, 31'd0, 31'd0, 31'd1, 31'd0, 31'd2, 31'd0, 31'd0};
      pending_lines.push_back(l);                  // crossing at x = 1 on the x axis
      l = '{-31'sd2, 31'd0, 31'd1, 31'd0, 31'd0, 31'd2, 31'd0, 31'd0};
      pending_lines.push_back(l);
      for (i = 0; i < 256; i++) begin
         l = {8{31'h40000000}};
         if (i & 1)   l.b1x = 31'h3fffffff;
         if (i & 2)   l.d1x = 31'h3fffffff;
         if (i & 4)   l.d1y = 31'd1;
         if (i & 8)   l.b2y = 31'h3fffffff;
         if (i & 16)  l.d2x = 31'h3fffffff;
         if (i & 32)  l.d2y = 31'h3fffffff;
         if (i & 64)  l.b1y = 31'h3fffffff;
         if (i & 128) l.b2x = 31'h3fffffff;
         if (i % 12 == 0) pending_lines.push_back(l);
      end
      l = '{31'd5, 31'd7, 31'd0, 31'd0, 31'd3, 31'd4, 31'd0, 31'd0};
      pending_lines.push_back(l);                  // both lines through the origin, denominator -1
      repeat (1050) pending_lines.push_back(rnd_lines());
      repeat (5) @(posedge clock);
      reset <= 0;
   end

   // sender
   int  send_gap = 0;
   int  sent = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            expected_points.push_back(predict_crossing(lines_t'(req_tdata)));
            sent = sent + 1;
         end
         if (sent == 500 && !drain_hold && expected_points.size() != 0) drain_hold = 1;
         if (drain_hold && expected_points.size() == 0) begin
            drain_hold = 0;
            sent = sent + 1;
         end
         if (req_tvalid && !req_tready) begin
            // hold the current request
         end else if (send_gap > 0 || drain_hold) begin
            if (send_gap > 0) send_gap = send_gap - 1;
            req_tvalid <= 0;
         end else if (pending_lines.size() != 0) begin
            if (!quiet && $urandom_range(0, 15) == 0) begin
               send_gap = $urandom_range(1, 9);
               req_tvalid <= 0;
            end else begin
               req_tdata <= pending_lines.pop_front();
               req_tvalid <= 1;
            end
         end else begin
            req_tvalid <= 0;
            stim_done = 1;
         end
         quiet = pending_lines.size() < 150;
      end
   end

   // receiver and checker
   int stall = 0;
   always @(posedge clock) begin
      cross_t e;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_points.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected response %h", rsp_tdata);
            end else begin
               e = expected_points.pop_front();
               if (rsp_tdata[63:0] !== e.x || rsp_tdata[127:64] !== e.y
                   || rsp_tuser !== e.st) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: exp x=%0d y=%0d st=%0d got x=%0d y=%0d st=%0d",
                              $signed(e.x), $signed(e.y), e.st, $signed(rsp_tdata[63:0]),
                              $signed(rsp_tdata[127:64]), rsp_tuser);
               end
            end
         end
         if (pending_lines.size() == 900 && hold_cycles == 0) hold_cycles = 400;
         if (hold_cycles > 1) begin
            hold_cycles = hold_cycles - 1;
            rsp_tready <= 0;
         end else if (stall > 0) begin
            stall = stall - 1;
            rsp_tready <= 0;
         end else if (!quiet && $urandom_range(0, 15) == 0) begin
            stall = $urandom_range(1, 9);
            rsp_tready <= 0;
         end else rsp_tready <= 1;
      end
   end

   initial begin
      int tail;
      tail = 0;
      while (!(stim_done && expected_points.size() == 0 && tail > 120)) begin
         @(posedge clock);
         cycles++;
         if (stim_done && expected_points.size() == 0) tail++;
         if (cycles > 200000) begin
            $display("CHECKS FAILED");
            $finish;
         end
      end
      if (mismatches == 0) $display("ALL CHECKS PASSED");
      else $display("CHECKS FAILED");
      $finish;
   end
endmodule

### sim.f
src/lli_pkg.sv
src/lli_front.sv
src/lli_div.sv
src/lli_back.sv
src/line_line_intersection.sv
src/lli_checker.sv
bench/tb_top.sv
